// ===== hdl/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Types and constants shared by the cycle phase PI corrector and its
// serial remainder unit.
// ----------------------------------------------------------------------------
package cpc_pkg;

	localparam int TIME_W = 64;
	localparam int CYC_W  = 30;
	localparam int CFG_W  = 30;
	localparam int CORR_W = 29;
	localparam int PERR_W = 31;
	localparam int INT_W  = 32;
	localparam int IDX_W  = 2;

	// register map
	localparam logic [IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [IDX_W-1:0] REG_CYCLE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_LEAD   = 2'd2;

	localparam logic [CYC_W-1:0] CYCLE_RST = 30'd1000000;
	localparam logic [CYC_W-1:0] LEAD_RST  = 30'd50000;

	// divisors of the proportional and integral terms
	localparam logic [6:0] P_DIV = 7'd100;
	localparam logic [4:0] I_DIV = 5'd20;

	localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
	localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MOD  = 6'b000010,
		ST_FOLD = 6'b000100,
		ST_PREP = 6'b001000,
		ST_CDIV = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

// ===== hdl/cpc_rem_unit.sv =====
// ----------------------------------------------------------------------------
// cpc_rem_unit
// Serial restoring remainder: 64-bit dividend modulo a 30-bit divisor,
// two dividend bits per cycle.
// ----------------------------------------------------------------------------
module cpc_rem_unit import cpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [CYC_W-1:0]  divisor,
	output logic [CYC_W-1:0]  remainder,
	output rem_stat_t         stat
);

	localparam int STEPS = TIME_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic [TIME_W-1:0] dvd_q;
	logic [CYC_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [CYC_W:0]    dv;
	logic [CYC_W:0]    r1;
	logic [CYC_W:0]    r2;
	logic [CYC_W-1:0]  rem1;
	logic [CYC_W-1:0]  rem2;

	always_comb begin
		dv   = {1'b0, divisor};
		r1   = {rem_q, dvd_q[TIME_W-1]};
		rem1 = (r1 >= dv) ? CYC_W'(r1 - dv) : r1[CYC_W-1:0];
		r2   = {rem1, dvd_q[TIME_W-2]};
		rem2 = (r2 >= dv) ? CYC_W'(r2 - dv) : r2[CYC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-3:0], 2'b00};
			rem_q <= rem2;
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/cycle_phase_pi_corrector.sv =====
// ----------------------------------------------------------------------------
// cycle_phase_pi_corrector
// Enabled: an input transfer passes the remainder unit, the fold and integral
// step and the 32-step serial division by the P and I divisors before
// out_valid rises; disabled, it goes straight to output. One item at a time.
// A finished result waits in the output register while the next item enters.
// Reset: async, active low; registers return to enable 0, cycle 1000000 ns,
// lead 50000 ns, integral and last phase error 0.
// ----------------------------------------------------------------------------
module cycle_phase_pi_corrector import cpc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [TIME_W-1:0] bus_time_ns,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [CORR_W-1:0] correction_ns,
	output logic signed [PERR_W-1:0] phase_error_ns
);

	localparam int CNT_W = $clog2(INT_W);

	logic              enable_q;
	logic [CYC_W-1:0]  cycle_q;
	logic [CYC_W-1:0]  lead_q;

	state_t            st_q;
	logic              vneg_q;
	logic              dis_q;
	logic signed [PERR_W-1:0] delta_q;
	logic signed [INT_W-1:0]  integral_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [INT_W-1:0]  qd_q;
	logic [INT_W-1:0]  qi_q;
	logic [6:0]        rd_q;
	logic [4:0]        ri_q;
	logic              sd_q;
	logic              si_q;

	logic              out_valid_q;
	logic [CORR_W-1:0] corr_q;
	logic [PERR_W-1:0] perr_q;

	logic              in_xfer;
	logic              out_free;
	logic [TIME_W-1:0] t_u;
	logic [TIME_W-1:0] lead64;
	logic              t_ge;
	logic [TIME_W-1:0] mag;
	logic              rem_start;
	logic [CYC_W-1:0]  rem;
	rem_stat_t         rs;

	logic signed [PERR_W-1:0] delta_nx;
	logic signed [INT_W-1:0]  integral_nx;
	logic [PERR_W-1:0]        dabs;
	logic [7:0]        xd;
	logic [5:0]        xi;
	logic              bd;
	logic              bi;
	logic [6:0]        rd_nx;
	logic [4:0]        ri_nx;
	logic [CORR_W-1:0] corr_nx;

	assign in_ready = (st_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// magnitude and sign of the exact difference bus_time - lead
	always_comb begin
		t_u    = bus_time_ns;
		lead64 = {{(TIME_W-CYC_W){1'b0}}, lead_q};
		t_ge   = !t_u[TIME_W-1] && (t_u >= lead64);
		mag    = t_ge ? (t_u - lead64) : (lead64 - t_u);
	end

	assign rem_start = in_xfer && enable_q;

	cpc_rem_unit u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (mag),
		.divisor   (cycle_q),
		.remainder (rem),
		.stat      (rs)
	);

	// fold into (-cycle, cycle/2] and step the integral
	always_comb begin
		if (cycle_q == '0) begin
			delta_nx = '0;
		end else if (!vneg_q && (rem > (cycle_q >> 1))) begin
			delta_nx = $signed({1'b0, rem}) - $signed({1'b0, cycle_q});
		end else if (vneg_q) begin
			delta_nx = -$signed({1'b0, rem});
		end else begin
			delta_nx = $signed({1'b0, rem});
		end
		integral_nx = integral_q;
		if (delta_nx > 0 && integral_q != INT_MAX) begin
			integral_nx = integral_q + 1'b1;
		end else if (delta_nx < 0 && integral_q != INT_MIN) begin
			integral_nx = integral_q - 1'b1;
		end
	end

	// one quotient bit per cycle for both constant divisions
	always_comb begin
		dabs    = delta_q[PERR_W-1] ? PERR_W'(-delta_q) : PERR_W'(delta_q);
		xd      = {rd_q, qd_q[INT_W-1]};
		bd      = (xd >= {1'b0, P_DIV});
		rd_nx   = bd ? 7'(xd - {1'b0, P_DIV}) : xd[6:0];
		xi      = {ri_q, qi_q[INT_W-1]};
		bi      = (xi >= {1'b0, I_DIV});
		ri_nx   = bi ? 5'(xi - {1'b0, I_DIV}) : xi[4:0];
		corr_nx = (sd_q ? qd_q[CORR_W-1:0] : CORR_W'(-qd_q[CORR_W-1:0]))
		        + (si_q ? qi_q[CORR_W-1:0] : CORR_W'(-qi_q[CORR_W-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			cycle_q  <= CYCLE_RST;
			lead_q   <= LEAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_CYCLE:  cycle_q  <= cfg_data;
				REG_LEAD:   lead_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			vneg_q      <= 1'b0;
			dis_q       <= 1'b0;
			delta_q     <= '0;
			integral_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_xfer) begin
						vneg_q <= !t_ge;
						dis_q  <= !enable_q;
						st_q   <= enable_q ? ST_MOD : ST_OUT;
					end
				end
				ST_MOD: begin
					if (rs.done) begin
						st_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					delta_q    <= delta_nx;
					integral_q <= integral_nx;
					st_q       <= ST_PREP;
				end
				ST_PREP: begin
					cnt_q <= CNT_W'(INT_W - 1);
					st_q  <= ST_CDIV;
				end
				ST_CDIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// serial divider datapath and output payload
	always_ff @(posedge clk) begin
		if (st_q == ST_PREP) begin
			sd_q <= delta_q[PERR_W-1];
			si_q <= integral_q[INT_W-1];
			qd_q <= {{(INT_W-PERR_W){1'b0}}, dabs};
			qi_q <= integral_q[INT_W-1] ? INT_W'(-integral_q) : INT_W'(integral_q);
			rd_q <= '0;
			ri_q <= '0;
		end else if (st_q == ST_CDIV) begin
			qd_q <= {qd_q[INT_W-2:0], bd};
			qi_q <= {qi_q[INT_W-2:0], bi};
			rd_q <= rd_nx;
			ri_q <= ri_nx;
		end
		if (st_q == ST_OUT && out_free) begin
			corr_q <= dis_q ? '0 : corr_nx;
			perr_q <= delta_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign correction_ns  = $signed(corr_q);
	assign phase_error_ns = $signed(perr_q);

	// remainder unit runs exactly while we wait on it
	a_mod_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MOD) |-> (rs.busy || rs.done))
		else $error("remainder unit idle while waiting for remainder");

	a_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		rs.done |-> (st_q == ST_MOD))
		else $error("remainder done outside of modulo phase");

	a_dis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && dis_q && out_free) |=> (correction_ns == '0))
		else $error("nonzero correction while disabled");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CDIV) |-> (rd_q < P_DIV && ri_q < I_DIV))
		else $error("constant divider remainder out of range");

endmodule

// ===== tb/phase_corrector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_corrector_checker
// Watches the configuration port and both streaming channels of the cycle
// phase PI corrector. It tracks the registers, the integral and the last phase
// error, works out the correction and phase error for every input transfer,
// and compares each output transfer against the oldest pending result.
// ----------------------------------------------------------------------------
module phase_corrector_checker import cpc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic signed [TIME_W-1:0] bus_time_ns,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [CORR_W-1:0] correction_ns,
	input  logic signed [PERR_W-1:0] phase_error_ns,
	output int                       mismatches,
	output int                       pending
);

	localparam longint PROP_DIV  = 100;
	localparam longint INTEG_DIV = 20;
	localparam int     MAX_REPORTS = 10;

	typedef struct packed {
		logic signed [CORR_W-1:0] corr;
		logic signed [PERR_W-1:0] perr;
	} corr_result_t;

	corr_result_t     expected_corrections[$];
	corr_result_t     oldest;
	logic             enable_q;
	logic [CYC_W-1:0] cycle_q;
	logic [CFG_W-1:0] lead_q;
	longint           integral_q;
	longint           last_err_q;
	int               reported;

	// Updates the integral and last error as the block does.
	function automatic corr_result_t predict_correction(input logic signed [TIME_W-1:0] t);
		logic signed [TIME_W+1:0] diff;
		logic [TIME_W+1:0]        mag;
		logic [TIME_W+1:0]        rem;
		longint                   err;
		longint                   cyc;
		longint                   corr;
		corr_result_t             r;
		if (!enable_q) begin
			r.corr = '0;
			r.perr = last_err_q[PERR_W-1:0];
			return r;
		end
		err = 0;
		cyc = cycle_q;
		if (cyc != 0) begin
			// exact difference, remainder truncated toward zero
			diff = $signed({{2{t[TIME_W-1]}}, t}) -
				$signed({{(TIME_W-CFG_W+2){1'b0}}, lead_q});
			mag = diff[TIME_W+1] ? -diff : diff;
			rem = mag % {{(TIME_W-CYC_W+2){1'b0}}, cycle_q};
			err = longint'(rem[TIME_W-1:0]);
			if (diff[TIME_W+1])
				err = -err;
			if (err > cyc / 2)
				err = err - cyc;
		end
		if (err > 0 && integral_q < INT_MAX)
			integral_q = integral_q + 1;
		if (err < 0 && integral_q > INT_MIN)
			integral_q = integral_q - 1;
		last_err_q = err;
		corr = -(err / PROP_DIV) - (integral_q / INTEG_DIV);
		r.corr = corr[CORR_W-1:0];
		r.perr = err[PERR_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q = 1'b0;
			cycle_q = CYCLE_RST;
			lead_q = LEAD_RST;
			integral_q = 0;
			last_err_q = 0;
			expected_corrections.delete();
			mismatches = 0;
			reported = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE: enable_q = cfg_data[0];
					REG_CYCLE:  cycle_q = cfg_data[CYC_W-1:0];
					REG_LEAD:   lead_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_corrections.push_back(predict_correction(bus_time_ns));
			if (out_valid && out_ready) begin
				if (expected_corrections.size() == 0) begin
					mismatches++;
					if (reported < MAX_REPORTS) begin
						reported++;
						$display("%0t: unexpected result, correction %0d phase error %0d",
							$realtime, correction_ns, phase_error_ns);
					end
				end else begin
					oldest = expected_corrections.pop_front();
					if (oldest.corr !== correction_ns || oldest.perr !== phase_error_ns) begin
						mismatches++;
						if (reported < MAX_REPORTS) begin
							reported++;
							$display("%0t: correction exp %0d got %0d, phase error exp %0d got %0d",
								$realtime, oldest.corr, correction_ns,
								oldest.perr, phase_error_ns);
						end
					end
				end
			end
			pending = expected_corrections.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the cycle phase PI corrector: a directed pass over the fold
// boundaries, zero cycle, disable and extreme times, then random phases under
// several register settings with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module testbench;
	import cpc_pkg::*;

	localparam int                       STALL_LIMIT = 5000;
	localparam int                       TAIL_CYCLES = 100;
	localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic [CFG_W-1:0]         CFG_ALL = '1;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [TIME_W-1:0] bus_time_ns;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [CORR_W-1:0] correction_ns;
	logic signed [PERR_W-1:0] phase_error_ns;

	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          burst_left = 8;
	bit          sender_eager;
	longint      cur_cycle;
	longint      cur_lead;
	logic [31:0] ready_pattern = '1;
	int          pattern_age = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cycle_phase_pi_corrector dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.bus_time_ns    (bus_time_ns),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.correction_ns  (correction_ns),
		.phase_error_ns (phase_error_ns)
	);

	phase_corrector_checker phase_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.bus_time_ns    (bus_time_ns),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.correction_ns  (correction_ns),
		.phase_error_ns (phase_error_ns),
		.mismatches     (fail_count),
		.pending        (pending)
	);

	// receiver: rotating ready pattern, reloaded whenever pattern_age wraps
	always @(posedge clk) begin
		if (pattern_age == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern <= '1;
				1: ready_pattern <= $urandom;
				2: ready_pattern <= $urandom & $urandom;
				default: ready_pattern <= $urandom | $urandom;
			endcase
		end else begin
			ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
		end
		pattern_age <= (pattern_age + 1) % 40;
		out_ready <= ready_pattern[0];
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic signed [TIME_W-1:0] t);
		int gap;
		in_valid <= 1'b1;
		bus_time_ns <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			if (sender_eager)
				gap = 0;
			else begin
				case ($urandom_range(0, 2))
					0: gap = 0;
					1: gap = $urandom_range(1, 8);
					default: gap = $urandom_range(9, 90);
				endcase
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait until every pending result has been transferred
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic en, input logic [CYC_W-1:0] cyc,
			input logic [CFG_W-1:0] lead);
		logic [CFG_W-2:0] junk;
		junk = (CFG_W-1)'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= REG_ENABLE;
		cfg_data <= {junk, en};
		@(posedge clk);
		cfg_index <= REG_CYCLE;
		cfg_data <= cyc;
		@(posedge clk);
		cfg_index <= REG_LEAD;
		cfg_data <= lead;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cycle = longint'(cyc);
		cur_lead = longint'(lead);
	endtask

	// times near cycle boundaries and fold points, near the lead, or full random
	function automatic logic signed [TIME_W-1:0] pick_bus_time();
		longint k;
		longint off;
		longint c;
		c = cur_cycle;
		case ($urandom_range(0, 9))
			0, 1, 2: return {$urandom, $urandom};
			3, 4, 5, 6: begin
				k = {$urandom, $urandom};
				k = k >>> $urandom_range(0, 62);
				case ($urandom_range(0, 4))
					0: off = longint'($urandom_range(0, 600)) - 300;
					1: off = c / 2 + longint'($urandom_range(0, 4)) - 2;
					2: off = c - longint'($urandom_range(0, 2));
					3: off = -(c / 2) - longint'($urandom_range(0, 2));
					default: off = longint'($urandom_range(0, 32'(c)));
				endcase
				return cur_lead + k * c + off;
			end
			default:
				return cur_lead + (longint'($urandom_range(0, 8)) - 4) * c
					+ longint'($urandom_range(0, 32'(c)));
		endcase
	endfunction

	task automatic run_phase(input logic en, input logic [CYC_W-1:0] cyc,
			input logic [CFG_W-1:0] lead, input int count);
		drain();
		apply_settings(en, cyc, lead);
		sender_eager = ($urandom_range(0, 3) == 0);
		repeat (count) send_item(pick_bus_time());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		in_valid = 1'b0;
		bus_time_ns = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur_cycle = longint'(CYCLE_RST);
		cur_lead = longint'(LEAD_RST);
		sender_eager = 1'b0;

		// disabled out of reset: zero correction, last error held
		send_item(64'sd123456789);
		send_item(-64'sd5);

		drain();
		apply_settings(1'b1, CYCLE_RST, LEAD_RST);
		send_item(64'sd50000);
		send_item(64'sd0);
		send_item(64'sd550000);
		send_item(64'sd550001);
		send_item(64'sd49999);
		send_item(64'sd1049999);
		send_item(T_MAX);
		send_item(T_MIN);
		send_item(-64'sd1);

		drain();
		apply_settings(1'b0, CYCLE_RST, LEAD_RST);
		send_item(64'sd777);
		send_item(T_MIN);

		// zero cycle length: no error, no integral step
		drain();
		apply_settings(1'b1, '0, 30'd12345);
		send_item(T_MAX);
		send_item(-64'sd99999);

		// widest cycle and lead: difference beyond the signed 64-bit range
		drain();
		apply_settings(1'b1, CFG_ALL, CFG_ALL);
		send_item(T_MIN);
		send_item(T_MAX);
		send_item(64'sd1610612734);
		send_item(64'sd1610612735);

		// odd cycle around the half-cycle fold
		drain();
		apply_settings(1'b1, 30'd1001, '0);
		send_item(64'sd500);
		send_item(64'sd501);
		send_item(-64'sd1000);

		run_phase(1'b1, 30'd1000, '0, 100);
		run_phase(1'b1, CYCLE_RST, LEAD_RST, 100);
		run_phase(1'b1, 30'd1000000000, 30'd1000000000, 80);
		run_phase(1'b1, CFG_ALL, '0, 80);
		run_phase(1'b0, 30'd777, 30'd5, 30);
		run_phase(1'b1, CYC_W'($urandom_range(1000, 1000000000)),
			CFG_W'($urandom_range(0, 1000000000)), 100);
		run_phase(1'b1, CYC_W'($urandom_range(1000, 1000000000)),
			CFG_W'($urandom_range(0, 1000000000)), 100);
		run_phase(1'b1, 30'd1, CFG_ALL, 20);
		run_phase(1'b1, '0, CFG_W'($urandom), 20);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== cycle_phase_pi_corrector.f =====
hdl/cpc_pkg.sv
hdl/cpc_rem_unit.sv
hdl/cycle_phase_pi_corrector.sv
tb/phase_corrector_checker.sv
tb/testbench.sv
